/* sv/urld_pkg.sv */
// package: constants, types and helpers of the utf-16 run-length decoder
`timescale 1ns / 1ps

package urld_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int CW_WIDE = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST = 16'hDC00;
  localparam logic [15:0] LOW_LAST = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
  localparam logic [31:0] RUN_MAX = 32'hFFFF_FFFF;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [1:0] {
    CMD_DECODE = 2'd0,
    CMD_FLUSH = 2'd1,
    CMD_DISCARD = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [31:0] run_length;
    logic last;
  } run_t;

  typedef struct packed {
    logic [1:0] count;
    run_t run0;
    run_t run1;
  } dec_res_t;

  // clamp a waiting count to the width of a run length
  function automatic logic [31:0] run_len_sat(input count_t c);
    logic [CW_WIDE-1:0] w;
    w = CW_WIDE'(c);
    if (w > CW_WIDE'(RUN_MAX)) begin
      return RUN_MAX;
    end else begin
      return w[31:0];
    end
  endfunction

endpackage

/* sv/urld_if.sv */
// interfaces: input and result channels with valid/ready handshake
`timescale 1ns / 1ps

interface urld_in_if;
  logic valid;
  logic ready;
  logic [1:0] cmd;
  logic [15:0] code_unit;
  logic [15:0] repeat_req;

  modport source (output valid, output cmd, output code_unit, output repeat_req,
                  input ready);
  modport sink (input valid, input cmd, input code_unit, input repeat_req,
                output ready);
endinterface

interface urld_out_if;
  logic valid;
  logic ready;
  logic [20:0] code_point;
  logic [31:0] run_length;
  logic last;

  modport source (output valid, output code_point, output run_length, output last,
                  input ready);
  modport sink (input valid, input code_point, input run_length, input last,
                output ready);
endinterface

/* sv/utf16_run_length_decoder.sv */
// top level: utf-16 run-length decoder with input register and result buffer
// An item with a repeat count enters an input register; from there it is decoded
// against the pending high surrogate and its waiting count, and its zero, one or
// two runs go into a two-slot result buffer. Items that give at most one run are
// taken one per cycle while the result channel takes runs without stalling; items
// that give two runs are held back by the single result channel draining the
// buffer one run at a time. An item's first run passes the input register and
// the result buffer before it reaches the output. Pending state clears on reset.
`timescale 1ns / 1ps

module utf16_run_length_decoder import urld_pkg::*; (
  input logic clk,
  input logic rst_n,
  urld_in_if.sink    in_ch,
  urld_out_if.source out_ch
);

  logic in_v_r;
  logic [1:0] cmd_r;
  logic [15:0] cu_r;
  logic [15:0] rep_r;
  logic [15:0] pend_high_r;
  logic [15:0] pend_high_nxt;
  count_t pend_count_r;
  count_t pend_count_nxt;
  dec_res_t res;
  logic [1:0] free;
  logic consume;
  logic take;

  assign consume = in_v_r && (free >= res.count);
  assign in_ch.ready = !in_v_r || consume;
  assign take = in_ch.valid && in_ch.ready;

  urld_decode u_decode (
    .cmd            (cmd_r),
    .code_unit      (cu_r),
    .repeat_req     (rep_r),
    .pend_high      (pend_high_r),
    .pend_count     (pend_count_r),
    .pend_high_nxt  (pend_high_nxt),
    .pend_count_nxt (pend_count_nxt),
    .res            (res)
  );

  urld_out_buf u_out_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (consume),
    .res    (res),
    .free   (free),
    .out_ch (out_ch)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      pend_high_r <= '0;
      pend_count_r <= '0;
    end else begin
      if (take) begin
        in_v_r <= 1'b1;
      end else if (consume) begin
        in_v_r <= 1'b0;
      end
      if (consume) begin
        pend_high_r <= pend_high_nxt;
        pend_count_r <= pend_count_nxt;
      end
    end
    if (take) begin
      cmd_r <= in_ch.cmd;
      cu_r <= in_ch.code_unit;
      rep_r <= in_ch.repeat_req;
    end
  end

endmodule

/* sv/urld_decode.sv */
// decode logic: one registered item and pending state to up to two runs
`timescale 1ns / 1ps

module urld_decode import urld_pkg::*; (
  input  logic [1:0]  cmd,
  input  logic [15:0] code_unit,
  input  logic [15:0] repeat_req,
  input  logic [15:0] pend_high,
  input  count_t      pend_count,
  output logic [15:0] pend_high_nxt,
  output count_t      pend_count_nxt,
  output dec_res_t    res
);

  run_t r0;
  run_t r1;
  logic r0_v;
  logic r1_v;
  logic [15:0] pairs;
  logic [15:0] leftover;
  count_t base;
  logic [COUNT_WIDTH:0] sum;

  always_comb begin
    r0 = '0;
    r1 = '0;
    r0_v = 1'b0;
    r1_v = 1'b0;
    pairs = '0;
    leftover = '0;
    base = pend_count;
    sum = '0;
    pend_high_nxt = pend_high;
    pend_count_nxt = pend_count;
    case (cmd_t'(cmd))
      CMD_FLUSH: begin
        r0_v = (pend_count != '0);
        r0.code_point = REPLACEMENT;
        r0.run_length = run_len_sat(pend_count);
        pend_high_nxt = '0;
        pend_count_nxt = '0;
      end
      CMD_DISCARD: begin
        pend_high_nxt = '0;
        pend_count_nxt = '0;
      end
      CMD_DECODE: begin
        if (repeat_req != '0) begin
          if (code_unit inside {[HIGH_FIRST:HIGH_LAST]}) begin
            // a different high surrogate flushes the waiting copies
            if (pend_count != '0 && pend_high != code_unit) begin
              r0_v = 1'b1;
              r0.code_point = REPLACEMENT;
              r0.run_length = run_len_sat(pend_count);
              base = '0;
            end
            sum = {1'b0, base} + (COUNT_WIDTH + 1)'(repeat_req);
            pend_count_nxt = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
            pend_high_nxt = code_unit;
          end else if (code_unit inside {[LOW_FIRST:LOW_LAST]}) begin
            pairs = (pend_count < COUNT_WIDTH'(repeat_req)) ? pend_count[15:0] : repeat_req;
            r0_v = (pairs != '0);
            r0.code_point = SUPP_BASE + 21'({pend_high[9:0], code_unit[9:0]});
            r0.run_length = 32'(pairs);
            if (pairs != '0) begin
              pend_count_nxt = pend_count - COUNT_WIDTH'(pairs);
              if (pend_count_nxt == '0) begin
                pend_high_nxt = '0;
              end
            end
            leftover = repeat_req - pairs;
            r1_v = (leftover != '0);
            r1.code_point = REPLACEMENT;
            r1.run_length = 32'(leftover);
          end else begin
            r0_v = (pend_count != '0);
            r0.code_point = REPLACEMENT;
            r0.run_length = run_len_sat(pend_count);
            pend_high_nxt = '0;
            pend_count_nxt = '0;
            r1_v = 1'b1;
            r1.code_point = 21'(code_unit);
            r1.run_length = 32'(repeat_req);
          end
        end
      end
      default: begin
      end
    endcase

    // pack valid runs to the front, mark the final one
    res.count = 2'(r0_v) + 2'(r1_v);
    res.run0 = r0_v ? r0 : r1;
    res.run0.last = !(r0_v && r1_v);
    res.run1 = r1;
    res.run1.last = 1'b1;
  end

endmodule

/* sv/urld_out_buf.sv */
// result buffer: two run slots in front of the result channel
`timescale 1ns / 1ps

module urld_out_buf import urld_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  dec_res_t res,
  output logic [1:0] free,
  urld_out_if.source out_ch
);

  run_t b0_r;
  run_t b1_r;
  run_t b0_nxt;
  run_t b1_nxt;
  logic v0_r;
  logic v1_r;
  logic v0_nxt;
  logic v1_nxt;
  logic pop;
  logic [1:0] remain;

  assign pop = v0_r && out_ch.ready;
  assign remain = 2'(v0_r) + 2'(v1_r) - 2'(pop);
  assign free = 2'd2 - remain;

  assign out_ch.valid = v0_r;
  assign out_ch.code_point = b0_r.code_point;
  assign out_ch.run_length = b0_r.run_length;
  assign out_ch.last = b0_r.last;

  always_comb begin
    b0_nxt = b0_r;
    b1_nxt = b1_r;
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    if (pop) begin
      b0_nxt = b1_r;
      v0_nxt = v1_r;
      v1_nxt = 1'b0;
    end
    // an item without runs leaves the slots untouched
    if (load && res.count != 2'd0) begin
      if (remain == 2'd0) begin
        b0_nxt = res.run0;
        b1_nxt = res.run1;
        v0_nxt = 1'b1;
        v1_nxt = (res.count == 2'd2);
      end else begin
        b1_nxt = res.run0;
        v1_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
    b0_r <= b0_nxt;
    b1_r <= b1_nxt;
  end

endmodule
